/* sv/mouse_packet_dead_reckoning_unit_macros.svh */
// assertion helpers for the top-level file that checks itself
`ifndef MOUSE_PACKET_DEAD_RECKONING_UNIT_MACROS_SVH
`define MOUSE_PACKET_DEAD_RECKONING_UNIT_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define MPDR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define MPDR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/mpdr_pkg.sv */
`default_nettype none

package mpdr_pkg;

    localparam int ANGLE_BITS_DEF   = 32;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_LEVER_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MM_PER_COUNT = 2'd1;

    localparam logic [CFG_DATA_W-1:0] LEVER_LENGTH_RST = 16'd25600;
    localparam logic [CFG_DATA_W-1:0] MM_PER_COUNT_RST = 16'd16384;

    // shared divider: numerator and divisor magnitudes
    localparam int DIV_NUM_W = 62;
    localparam int DIV_DEN_W = 46;

    localparam int CORDIC_W = 34;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [29:0] RAD_TO_TURN = 30'd683565276;
    localparam logic [32:0] EPS_TURN    = 33'd68357;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCALE,
        OP_MUL,
        OP_DIV_ALPHA,
        OP_TAKE_ALPHA,
        OP_DIV_XQ,
        OP_TAKE_XQ,
        OP_DIV_XA,
        OP_TAKE_XA,
        OP_SQUARE,
        OP_SINC_SMALL,
        OP_COR_XA,
        OP_DIV_SINC,
        OP_TAKE_SINC,
        OP_CALC_R,
        OP_COR_DIR,
        OP_CALC_DX,
        OP_CALC_DY,
        OP_UPDATE
    } mpdr_op_t;

    typedef struct packed {
        mpdr_op_t op;
    } mpdr_cmd_t;

    typedef struct packed {
        logic div_done;
        logic cordic_done;
        logic x_small;
    } mpdr_status_t;

    // atan(2^-i) as a fraction of a full turn
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        case (idx)
            5'd0:    return 32'h20000000;
            5'd1:    return 32'h12E4051E;
            5'd2:    return 32'h09FB385B;
            5'd3:    return 32'h051111D4;
            5'd4:    return 32'h028B0D43;
            5'd5:    return 32'h0145D7E1;
            5'd6:    return 32'h00A2F61E;
            5'd7:    return 32'h00517C55;
            5'd8:    return 32'h0028BE53;
            5'd9:    return 32'h00145F2F;
            5'd10:   return 32'h000A2F98;
            5'd11:   return 32'h000517CC;
            5'd12:   return 32'h00028BE6;
            5'd13:   return 32'h000145F3;
            5'd14:   return 32'h0000A2FA;
            5'd15:   return 32'h0000517D;
            5'd16:   return 32'h000028BE;
            5'd17:   return 32'h0000145F;
            5'd18:   return 32'h00000A30;
            5'd19:   return 32'h00000518;
            5'd20:   return 32'h0000028C;
            5'd21:   return 32'h00000146;
            5'd22:   return 32'h000000A3;
            5'd23:   return 32'h00000051;
            5'd24:   return 32'h00000029;
            5'd25:   return 32'h00000014;
            5'd26:   return 32'h0000000A;
            5'd27:   return 32'h00000005;
            5'd28:   return 32'h00000003;
            5'd29:   return 32'h00000001;
            default: return 32'h00000000;
        endcase
    endfunction

    function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31])
        begin
            return s[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        return s[31:0];
    endfunction

endpackage

`default_nettype wire

/* sv/mpdr_divider.sv */
`default_nettype none

module mpdr_divider import mpdr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [DIV_NUM_W-1:0] num,
    input  wire logic [DIV_DEN_W-1:0] den,
    output logic                      done,
    output logic [DIV_NUM_W-1:0]      quo
);

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic                 run_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_NUM_W-1:0] quo_reg;

    logic [DIV_DEN_W:0]   rem_shift;
    logic [DIV_DEN_W+1:0] diff;
    logic                 fits;

    // restoring division, one quotient bit a cycle
    assign rem_shift = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, den_reg};
    assign fits      = !diff[DIV_DEN_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_NUM_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= den;
            quo_reg <= num;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? diff[DIV_DEN_W-1:0] : rem_shift[DIV_DEN_W-1:0];
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

/* sv/mpdr_cordic.sv */
`default_nettype none

module mpdr_cordic import mpdr_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [31:0]                angle,
    output logic                            done,
    output logic signed [CORDIC_W-1:0]      cos_out,
    output logic signed [CORDIC_W-1:0]      sin_out
);

    localparam int CNT_W = $clog2(CORDIC_STEPS + 1);

    logic                       run_reg;
    logic                       done_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       flip_reg;
    logic signed [CORDIC_W-1:0] x_reg;
    logic signed [CORDIC_W-1:0] y_reg;
    logic signed [CORDIC_W-1:0] z_reg;

    logic [31:0]                sum_quarter;
    logic                       flip;
    logic [31:0]                folded;
    logic signed [CORDIC_W-1:0] x_sh;
    logic signed [CORDIC_W-1:0] y_sh;
    logic signed [CORDIC_W-1:0] atan_step;

    // fold into [-1/4, 1/4) turn by a half turn, negate at the end
    assign sum_quarter = angle + 32'h40000000;
    assign flip        = sum_quarter[31];
    assign folded      = flip ? (angle ^ 32'h80000000) : angle;

    assign x_sh      = x_reg >>> cnt_reg;
    assign y_sh      = y_reg >>> cnt_reg;
    assign atan_step = $signed({2'b00, atan_turn(5'(cnt_reg))});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            flip_reg <= flip;
            x_reg    <= CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= CORDIC_W'($signed(folded));
        end
        else if (run_reg)
        begin
            if (!z_reg[CORDIC_W-1])
            begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
                z_reg <= z_reg - atan_step;
            end
            else
            begin
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
                z_reg <= z_reg + atan_step;
            end
        end
    end

    assign done    = done_reg;
    assign cos_out = flip_reg ? -x_reg : x_reg;
    assign sin_out = flip_reg ? -y_reg : y_reg;

endmodule

`default_nettype wire

/* sv/mpdr_datapath.sv */
`default_nettype none

module mpdr_datapath import mpdr_pkg::*;
#(
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire mpdr_cmd_t             cmd,
    output mpdr_status_t               status,
    input  wire logic [7:0]            byte0,
    input  wire logic [7:0]            byte1,
    input  wire logic [7:0]            byte2,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic signed [31:0]         pos_x,
    output logic signed [31:0]         pos_y,
    output logic [31:0]                heading,
    output logic [31:0]                path_length,
    output logic signed [31:0]         sum_turn,
    output logic signed [31:0]         sum_forward,
    output logic [31:0]                packet_count
);

    localparam logic [31:0] ANGLE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

    // configuration and running totals
    logic [15:0]        lever_reg;
    logic [15:0]        mm_reg;
    logic signed [31:0] x_acc_reg;
    logic signed [31:0] y_acc_reg;
    logic [31:0]        angle_acc_reg;
    logic [31:0]        dist_acc_reg;
    logic               last_y_nonneg_reg;
    logic signed [31:0] turn_total_reg;
    logic signed [31:0] fwd_total_reg;
    logic [31:0]        packets_reg;

    // per packet work registers
    logic [7:0]         b0_reg;
    logic [7:0]         b1_reg;
    logic [7:0]         b2_reg;
    logic signed [16:0] turn_reg;
    logic signed [16:0] fwd_reg;
    logic signed [47:0] prod_reg;
    logic               div_neg_reg;
    logic [32:0]        alpha_reg;
    logic signed [45:0] xq_reg;
    logic [31:0]        xa_reg;
    logic [51:0]        sq_reg;
    logic signed [37:0] sinc_reg;
    logic signed [24:0] r_reg;
    logic signed [31:0] dx_reg;
    logic signed [31:0] dy_reg;

    logic signed [7:0]  h_cnt;
    logic signed [7:0]  v_cnt;
    logic [15:0]        lever_eff;
    logic [16:0]        two_lever;
    logic signed [24:0] turn_mul;
    logic signed [24:0] fwd_mul;
    logic signed [24:0] turn_rnd;
    logic signed [24:0] fwd_rnd;
    logic signed [47:0] prod_w;
    logic [47:0]        abs_prod;
    logic [16:0]        abs_turn;
    logic [45:0]        abs_xq;
    logic [CORDIC_W-1:0] abs_sin;

    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_neg;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quo;

    logic                       cor_start;
    logic [31:0]                cor_angle;
    logic                       cor_done;
    logic signed [CORDIC_W-1:0] cor_cos;
    logic signed [CORDIC_W-1:0] cor_sin;

    logic [32:0]        alpha_q;
    logic [32:0]        alpha_signed;
    logic [32:0]        bias;
    logic [31:0]        phi;
    logic signed [26:0] xq_lo;
    logic signed [53:0] sq_w;
    logic [52:0]        sq_rnd;
    logic [44:0]        recip_w;
    logic [37:0]        sinc_small;
    logic signed [54:0] rp_w;
    logic signed [54:0] rr_w;
    logic signed [CORDIC_W-1:0] trig_sel;
    logic signed [58:0] dp_w;
    logic signed [58:0] dr_w;
    logic signed [31:0] d_step;
    logic [24:0]        abs_r;
    logic [32:0]        dist_sum;

    assign h_cnt     = {b0_reg[1:0], b1_reg[5:0]};
    assign v_cnt     = {b0_reg[3:2], b2_reg[5:0]};
    assign lever_eff = (lever_reg == 16'd0) ? 16'd1 : lever_reg;
    assign two_lever = {lever_eff, 1'b0};

    // counts to 1/256 mm, rounded half up
    assign turn_mul = v_cnt * $signed({1'b0, mm_reg});
    assign fwd_mul  = h_cnt * $signed({1'b0, mm_reg});
    assign turn_rnd = turn_mul + 25'sd128;
    assign fwd_rnd  = fwd_mul + 25'sd128;

    assign prod_w   = turn_reg * $signed({1'b0, RAD_TO_TURN});
    assign abs_prod = prod_reg[47] ? (48'd0 - prod_reg) : prod_reg;
    assign abs_turn = turn_reg[16] ? (17'd0 - turn_reg) : turn_reg;
    assign abs_xq   = xq_reg[45] ? (46'd0 - xq_reg) : xq_reg;
    assign abs_sin  = cor_sin[CORDIC_W-1] ? (CORDIC_W'(0) - cor_sin) : cor_sin;

    // operand selection for the shared divider
    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = abs_xq;
        div_neg   = 1'b0;
        case (cmd.op)
            OP_DIV_ALPHA:
            begin
                div_start = 1'b1;
                div_num   = DIV_NUM_W'(abs_prod[46:0]) + DIV_NUM_W'(lever_eff[15:1]);
                div_den   = DIV_DEN_W'(lever_eff);
                div_neg   = prod_reg[47];
            end
            OP_DIV_XQ:
            begin
                div_start = 1'b1;
                div_num   = (DIV_NUM_W'(abs_turn) << 30) + DIV_NUM_W'(lever_eff);
                div_den   = DIV_DEN_W'(two_lever);
                div_neg   = turn_reg[16];
            end
            OP_DIV_XA:
            begin
                div_start = 1'b1;
                div_num   = DIV_NUM_W'(abs_prod[46:0]) + DIV_NUM_W'(lever_eff);
                div_den   = DIV_DEN_W'(two_lever);
                div_neg   = prod_reg[47];
            end
            OP_DIV_SINC:
            begin
                div_start = 1'b1;
                div_num   = DIV_NUM_W'(abs_sin[31:0]) << 30;
                div_den   = abs_xq;
                div_neg   = cor_sin[CORDIC_W-1] ^ xq_reg[45];
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    mpdr_divider u_divider
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign phi       = alpha_reg[32:1] + 32'h40000000;
    assign cor_start = (cmd.op == OP_COR_XA) || (cmd.op == OP_COR_DIR);
    assign cor_angle = (cmd.op == OP_COR_XA) ? (xa_reg & ANGLE_MASK)
                                             : ((angle_acc_reg + phi) & ANGLE_MASK);

    mpdr_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .angle   (cor_angle),
        .done    (cor_done),
        .cos_out (cor_cos),
        .sin_out (cor_sin)
    );

    assign alpha_q      = div_quo[32:0];
    assign alpha_signed = div_neg_reg ? (33'd0 - alpha_q) : alpha_q;
    assign bias         = last_y_nonneg_reg ? EPS_TURN : (33'd0 - EPS_TURN);

    // sinc near zero: 1 - x^2/6, the divide by 3 done by reciprocal
    assign xq_lo      = xq_reg[26:0];
    assign sq_w       = xq_lo * xq_lo;
    assign sq_rnd     = {1'b0, sq_reg} + 53'd3221225472;
    assign recip_w    = sq_rnd[52:31] * 23'd5592406;
    assign sinc_small = 38'd1073741824 - {17'd0, recip_w[44:24]};

    assign rp_w = fwd_reg * sinc_reg;
    assign rr_w = rp_w + 55'sd536870912;

    assign trig_sel = (cmd.op == OP_CALC_DY) ? cor_sin : cor_cos;
    assign dp_w     = r_reg * trig_sel;
    assign dr_w     = dp_w + 59'sd536870912;
    assign d_step   = 32'($signed(dr_w[58:30]));

    assign abs_r    = r_reg[24] ? (25'd0 - r_reg) : r_reg;
    assign dist_sum = {1'b0, dist_acc_reg} + {8'd0, abs_r};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lever_reg         <= LEVER_LENGTH_RST;
            mm_reg            <= MM_PER_COUNT_RST;
            x_acc_reg         <= '0;
            y_acc_reg         <= '0;
            angle_acc_reg     <= '0;
            dist_acc_reg      <= '0;
            last_y_nonneg_reg <= 1'b1;
            turn_total_reg    <= '0;
            fwd_total_reg     <= '0;
            packets_reg       <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_LEVER_LENGTH: lever_reg <= cfg_data;
                    REG_MM_PER_COUNT: mm_reg    <= cfg_data;
                    default:          lever_reg <= lever_reg;
                endcase
            end
            if (cmd.op == OP_UPDATE)
            begin
                x_acc_reg         <= sat_add32(x_acc_reg, dx_reg);
                y_acc_reg         <= sat_add32(y_acc_reg, dy_reg);
                angle_acc_reg     <= (angle_acc_reg + alpha_reg[31:0]) & ANGLE_MASK;
                dist_acc_reg      <= dist_sum[32] ? 32'hFFFFFFFF : dist_sum[31:0];
                last_y_nonneg_reg <= !dy_reg[31];
                turn_total_reg    <= sat_add32(turn_total_reg, 32'(turn_reg));
                fwd_total_reg     <= sat_add32(fwd_total_reg, 32'(fwd_reg));
                packets_reg       <= packets_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            div_neg_reg <= div_neg;
        end
        case (cmd.op)
            OP_LOAD:
            begin
                b0_reg <= byte0;
                b1_reg <= byte1;
                b2_reg <= byte2;
            end
            OP_SCALE:
            begin
                turn_reg <= turn_rnd[24:8];
                fwd_reg  <= fwd_rnd[24:8];
            end
            OP_MUL:        prod_reg  <= prod_w;
            OP_TAKE_ALPHA: alpha_reg <= alpha_signed + bias;
            OP_TAKE_XQ:    xq_reg    <= div_neg_reg ? (46'd0 - div_quo[45:0]) : div_quo[45:0];
            OP_TAKE_XA:    xa_reg    <= div_neg_reg ? (32'd0 - div_quo[31:0]) : div_quo[31:0];
            OP_SQUARE:     sq_reg    <= sq_w[51:0];
            OP_SINC_SMALL: sinc_reg  <= sinc_small;
            OP_TAKE_SINC:  sinc_reg  <= div_neg_reg ? (38'd0 - div_quo[37:0]) : div_quo[37:0];
            OP_CALC_R:     r_reg     <= rr_w[54:30];
            OP_CALC_DX:    dx_reg    <= d_step;
            OP_CALC_DY:    dy_reg    <= d_step;
            default:       b0_reg    <= b0_reg;
        endcase
    end

    assign status.div_done    = div_done;
    assign status.cordic_done = cor_done;
    assign status.x_small     = (abs_xq[45:26] == 20'd0);

    assign pos_x        = x_acc_reg;
    assign pos_y        = y_acc_reg;
    assign heading      = angle_acc_reg;
    assign path_length  = dist_acc_reg;
    assign sum_turn     = turn_total_reg;
    assign sum_forward  = fwd_total_reg;
    assign packet_count = packets_reg;

endmodule

`default_nettype wire

/* sv/mpdr_ctrl.sv */
`default_nettype none

module mpdr_ctrl import mpdr_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  wire logic         out_ready,
    input  wire mpdr_status_t status,
    output mpdr_cmd_t         cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_SCALE,
        S_MUL,
        S_DIV_A,
        S_WAIT_A,
        S_DIV_X,
        S_WAIT_X,
        S_DIV_XA,
        S_WAIT_XA,
        S_SQUARE,
        S_SINC_SMALL,
        S_COR_XA,
        S_WAIT_COR_XA,
        S_DIV_S,
        S_WAIT_S,
        S_CALC_R,
        S_COR_DIR,
        S_WAIT_DIR,
        S_CALC_DX,
        S_CALC_DY,
        S_UPDATE
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   update_ok;

    // totals may only move once the previous result has been taken
    assign update_ok = !out_valid_reg || out_ready;

    // a result transfer clears valid, a totals update sets it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if ((state_reg == S_UPDATE) && update_ok)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_comb
    begin
        cmd.op = OP_NONE;
        case (state_reg)
            S_IDLE:        cmd.op = in_valid ? OP_LOAD : OP_NONE;
            S_SCALE:       cmd.op = OP_SCALE;
            S_MUL:         cmd.op = OP_MUL;
            S_DIV_A:       cmd.op = OP_DIV_ALPHA;
            S_WAIT_A:      cmd.op = status.div_done ? OP_TAKE_ALPHA : OP_NONE;
            S_DIV_X:       cmd.op = OP_DIV_XQ;
            S_WAIT_X:      cmd.op = status.div_done ? OP_TAKE_XQ : OP_NONE;
            S_DIV_XA:      cmd.op = OP_DIV_XA;
            S_WAIT_XA:     cmd.op = status.div_done ? OP_TAKE_XA : OP_NONE;
            S_SQUARE:      cmd.op = OP_SQUARE;
            S_SINC_SMALL:  cmd.op = OP_SINC_SMALL;
            S_COR_XA:      cmd.op = OP_COR_XA;
            S_WAIT_COR_XA: cmd.op = OP_NONE;
            S_DIV_S:       cmd.op = OP_DIV_SINC;
            S_WAIT_S:      cmd.op = status.div_done ? OP_TAKE_SINC : OP_NONE;
            S_CALC_R:      cmd.op = OP_CALC_R;
            S_COR_DIR:     cmd.op = OP_COR_DIR;
            S_WAIT_DIR:    cmd.op = OP_NONE;
            S_CALC_DX:     cmd.op = OP_CALC_DX;
            S_CALC_DY:     cmd.op = OP_CALC_DY;
            S_UPDATE:      cmd.op = update_ok ? OP_UPDATE : OP_NONE;
            default:       cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_SCALE;
                    end
                end
                S_SCALE:  state_reg <= S_MUL;
                S_MUL:    state_reg <= S_DIV_A;
                S_DIV_A:  state_reg <= S_WAIT_A;
                S_WAIT_A:
                begin
                    if (status.div_done)
                    begin
                        state_reg <= S_DIV_X;
                    end
                end
                S_DIV_X:  state_reg <= S_WAIT_X;
                S_WAIT_X:
                begin
                    if (status.div_done)
                    begin
                        state_reg <= S_DIV_XA;
                    end
                end
                S_DIV_XA: state_reg <= S_WAIT_XA;
                S_WAIT_XA:
                begin
                    if (status.div_done)
                    begin
                        state_reg <= status.x_small ? S_SQUARE : S_COR_XA;
                    end
                end
                S_SQUARE:     state_reg <= S_SINC_SMALL;
                S_SINC_SMALL: state_reg <= S_CALC_R;
                S_COR_XA:     state_reg <= S_WAIT_COR_XA;
                S_WAIT_COR_XA:
                begin
                    if (status.cordic_done)
                    begin
                        state_reg <= S_DIV_S;
                    end
                end
                S_DIV_S:  state_reg <= S_WAIT_S;
                S_WAIT_S:
                begin
                    if (status.div_done)
                    begin
                        state_reg <= S_CALC_R;
                    end
                end
                S_CALC_R:  state_reg <= S_COR_DIR;
                S_COR_DIR: state_reg <= S_WAIT_DIR;
                S_WAIT_DIR:
                begin
                    if (status.cordic_done)
                    begin
                        state_reg <= S_CALC_DX;
                    end
                end
                S_CALC_DX: state_reg <= S_CALC_DY;
                S_CALC_DY: state_reg <= S_UPDATE;
                S_UPDATE:
                begin
                    if (update_ok)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* sv/mouse_packet_dead_reckoning_unit.sv */
// channel  dir  handshake              payload
// in       in   in_valid / in_ready    byte0, byte1, byte2
// out      out  out_valid / out_ready  pos_x, pos_y, heading, path_length,
//                                      sum_turn, sum_forward, packet_count
// cfg      in   cfg_wr_en              cfg_index, cfg_data
//
// one packet at a time (16 cordic steps); the work per packet is set
// by the shared one-bit-a-cycle divider (three or four passes)
// and the iterative cordic (one or two passes)
// a new packet is taken while the previous result still waits on out_ready
// the totals only move once that result has been transferred
// rst_n clears totals and control at once; no clearing pass
`default_nettype none

`include "mouse_packet_dead_reckoning_unit_macros.svh"

module mouse_packet_dead_reckoning_unit import mpdr_pkg::*;
#(
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [7:0]            byte0,
    input  wire logic [7:0]            byte1,
    input  wire logic [7:0]            byte2,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic signed [31:0]         pos_x,
    output logic signed [31:0]         pos_y,
    output logic [31:0]                heading,
    output logic [31:0]                path_length,
    output logic signed [31:0]         sum_turn,
    output logic signed [31:0]         sum_forward,
    output logic [31:0]                packet_count,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    mpdr_cmd_t    cmd;
    mpdr_status_t status;

    mpdr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    mpdr_datapath #(
        .ANGLE_BITS   (ANGLE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .byte0        (byte0),
        .byte1        (byte1),
        .byte2        (byte2),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .heading      (heading),
        .path_length  (path_length),
        .sum_turn     (sum_turn),
        .sum_forward  (sum_forward),
        .packet_count (packet_count)
    );

    // only one packet in work at a time
    `MPDR_ASSERT_NEXT(a_one_in_work, in_valid && in_ready, !in_ready, "second packet taken while busy")
    // a fresh result always carries exactly one more packet
    `MPDR_ASSERT_SAME(a_count_step, $rose(out_valid), packet_count == $past(packet_count) + 32'd1, "packet count did not advance by one")
    // a result only appears at the end of the work sequence
    `MPDR_ASSERT_SAME(a_result_after_work, $rose(out_valid), $past(!in_ready) && $past(cmd.op == OP_UPDATE), "result without totals update")

endmodule

`default_nettype wire
